FILE: sv/kslp_pkg.sv
// Shared types and constants for the key short/long press scanner.
package kslp_pkg;

  localparam int unsigned NUM_KEYS_DEF = 9;
  localparam int unsigned TICK_W       = 32;
  localparam int unsigned HOLD_W       = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REMOTE_HIGH = 2'd2;

  localparam logic [HOLD_W-1:0] LONG_TICKS_RST = 16'd1000;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_REMOTE = 2'd3
  } kslp_event_e;

  typedef struct packed {
    logic [HOLD_W-1:0] long_ticks;
    logic              local_high;
    logic              remote_high;
  } kslp_cfg_t;

  // One key's state entry
  typedef struct packed {
    logic              level;
    logic              long_fired;
    logic [TICK_W-1:0] press_tick;
  } kslp_entry_t;

endpackage

FILE: sv/kslp_state_mem.sv
// Key state memory: one write and one registered read port, valid bits for reset.
module kslp_state_mem
  import kslp_pkg::*;
#(
  parameter int unsigned DEPTH = NUM_KEYS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output kslp_entry_t   rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  kslp_entry_t   wr_data_i
);

  kslp_entry_t            mem_q [DEPTH];
  kslp_entry_t            rdata_q;
  logic [DEPTH-1:0]       valid_q;
  logic                   rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // never-written entry reads as the reset state (all zero)
  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

FILE: sv/kslp_scan_engine.sv
// Scan sequencer: read-modify-write of key state, one key per cycle, early exit.
module kslp_scan_engine
  import kslp_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF,
  parameter int unsigned KW       = $clog2(NUM_KEYS + 1),
  parameter int unsigned AW       = $clog2(NUM_KEYS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kslp_cfg_t           cfg_i,
  input  logic                start_i,
  input  logic [NUM_KEYS-1:0] pins_i,
  input  logic [TICK_W-1:0]   now_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output logic [KW-1:0]       res_key_o,
  output kslp_event_e         res_kind_o,
  output logic [TICK_W-1:0]   res_tick_o,
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_o,
  input  kslp_entry_t         rd_data_i,
  output logic                wr_en_o,
  output logic [AW-1:0]       wr_addr_o,
  output kslp_entry_t         wr_data_o
);

  typedef enum logic {S_IDLE, S_SCAN} state_e;

  state_e                state_q;
  logic [NUM_KEYS-1:0]   pins_q;
  logic [TICK_W-1:0]     now_q;
  logic [AW-1:0]         idx_q;
  logic                  res_valid_q;
  logic [KW-1:0]         res_key_q;
  kslp_event_e           res_kind_q;
  logic [TICK_W-1:0]     res_tick_q;

  logic                  remote_act;
  logic                  cur;
  logic                  changed;
  logic                  keep_long;
  logic [TICK_W-1:0]     new_tick;
  logic [TICK_W-1:0]     held;
  logic                  short_ev;
  logic                  long_ev;
  logic                  last_key;

  assign remote_act = (pins_i[NUM_KEYS-1] == cfg_i.remote_high);

  // per-key update on the entry that arrived from memory
  always_comb begin
    cur       = (pins_q[idx_q] == cfg_i.local_high);
    changed   = (cur != rd_data_i.level);
    keep_long = (changed && cur) ? 1'b0 : rd_data_i.long_fired;
    new_tick  = changed ? now_q : rd_data_i.press_tick;
    held      = now_q - new_tick;
    short_ev  = changed && !cur && !rd_data_i.long_fired;
    long_ev   = cur && !keep_long && (held > TICK_W'(cfg_i.long_ticks));
    last_key  = (idx_q == AW'(NUM_KEYS - 1));
  end

  // next read is issued while the current key is written back
  always_comb begin
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    if (state_q == S_IDLE) begin
      rd_en_o = start_i && !remote_act;
    end else if (!(short_ev || long_ev) && !last_key) begin
      rd_en_o   = 1'b1;
      rd_addr_o = idx_q + AW'(1);
    end
  end

  assign wr_en_o   = (state_q == S_SCAN) && (changed || long_ev);
  assign wr_addr_o = idx_q;
  assign wr_data_o = '{level: cur, long_fired: keep_long | long_ev, press_tick: new_tick};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      idx_q       <= '0;
      pins_q      <= '0;
      now_q       <= '0;
      res_key_q   <= '0;
      res_kind_q  <= EV_NONE;
      res_tick_q  <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            pins_q <= pins_i;
            now_q  <= now_i;
            idx_q  <= '0;
            if (remote_act) begin
              res_valid_q <= 1'b1;
              res_key_q   <= KW'(NUM_KEYS - 1);
              res_kind_q  <= EV_REMOTE;
              res_tick_q  <= '0;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (short_ev || long_ev) begin
            state_q     <= S_IDLE;
            res_valid_q <= 1'b1;
            res_key_q   <= KW'(idx_q);
            res_kind_q  <= short_ev ? EV_SHORT : EV_LONG;
            res_tick_q  <= now_q;
          end else if (last_key) begin
            state_q     <= S_IDLE;
            res_valid_q <= 1'b1;
            res_key_q   <= KW'(NUM_KEYS);
            res_kind_q  <= EV_NONE;
            res_tick_q  <= '0;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE) || res_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_key_o   = res_key_q;
  assign res_kind_o  = res_kind_q;
  assign res_tick_o  = res_tick_q;

endmodule

FILE: sv/key_short_long_press_scanner_top.sv
// Top level of the key short/long press scanner.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-----------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready| tdata: pin_levels, now_tick
//  m_axis    | out       | m_axis_tvalid/m_axis_tready| tdata: key_index, event_kind, tick
//  cfg       | in        | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
//  Steps: with the remote pin active, the accept goes to the engine's result register, then the
//  output register; otherwise the accept, then one visited key at a time (up to NUM_KEYS, up to
//  the first event), then the result and output registers. The key state memory's one read and
//  one write port set the pace: one key read, updated and written back per cycle.
//  Reset: key state reads as released/zero through per-entry valid bits, no clearing pass.
//  Stalls: a new transaction is taken only once the engine is idle and the previous result
//  has left or is leaving the output register; a held output does not block a running scan.
module key_short_long_press_scanner_top
  import kslp_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF,
  parameter int unsigned KW       = $clog2(NUM_KEYS + 1),
  parameter int unsigned AW       = $clog2(NUM_KEYS),
  parameter int unsigned IN_W     = ((NUM_KEYS + TICK_W + 7) / 8) * 8,
  parameter int unsigned OUT_W    = ((KW + 2 + TICK_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata from bit 0: pin_levels [NUM_KEYS], now_tick [32], zero fill
  input  logic [IN_W-1:0]       s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata from bit 0: key_index [KW], event_kind [2], event_tick [32], zero fill
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  kslp_cfg_t           cfg_q;
  logic                busy;
  logic                start;
  logic                res_valid;
  logic [KW-1:0]       res_key;
  kslp_event_e         res_kind;
  logic [TICK_W-1:0]   res_tick;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  kslp_entry_t         rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  kslp_entry_t         wr_data;
  logic                out_valid_q;
  logic [KW-1:0]       out_key_q;
  logic [1:0]          out_kind_q;
  logic [TICK_W-1:0]   out_tick_q;

  // the user must write config only while idle; not enforced here, so always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{long_ticks: LONG_TICKS_RST, local_high: 1'b1, remote_high: 1'b1};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LONG_TICKS:  cfg_q.long_ticks  <= cfg_data_i;
        REG_LOCAL_HIGH:  cfg_q.local_high  <= cfg_data_i[0];
        REG_REMOTE_HIGH: cfg_q.remote_high <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // take a scan when the engine is free and the output slot is free or draining
  assign s_axis_tready = !busy && (!out_valid_q || m_axis_tready);
  assign start         = s_axis_tvalid && s_axis_tready;

  kslp_scan_engine #(
    .NUM_KEYS (NUM_KEYS),
    .KW       (KW),
    .AW       (AW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (start),
    .pins_i      (s_axis_tdata[NUM_KEYS-1:0]),
    .now_i       (s_axis_tdata[NUM_KEYS+TICK_W-1:NUM_KEYS]),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_key_o   (res_key),
    .res_kind_o  (res_kind),
    .res_tick_o  (res_tick),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  kslp_state_mem #(
    .DEPTH (NUM_KEYS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // output register; the engine only finishes into a free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_key_q  <= res_key;
      out_kind_q <= res_kind;
      out_tick_q <= res_tick;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_tick_q, out_kind_q, out_key_q});

endmodule

FILE: verif/kslp_event_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the key press scanner: predicts each scan's event and checks the result stream.
module kslp_event_checker
  import kslp_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF,
  parameter int unsigned KW       = $clog2(NUM_KEYS + 1),
  parameter int unsigned IN_W     = ((NUM_KEYS + TICK_W + 7) / 8) * 8,
  parameter int unsigned OUT_W    = ((KW + 2 + TICK_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_W-1:0]      m_axis_tdata,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    errors_o
);

  localparam int unsigned EV_W = KW + 2 + TICK_W;

  // key_index sits in the low bits, as on the bus
  typedef struct packed {
    logic [TICK_W-1:0] tick;
    kslp_event_e       kind;
    logic [KW-1:0]     key_index;
  } scan_event_t;

  kslp_cfg_t           cfg;
  logic [NUM_KEYS-1:0] key_down;
  logic [NUM_KEYS-1:0] long_done;
  logic [TICK_W-1:0]   press_at [NUM_KEYS];
  scan_event_t         expected_events [$];
  int                  fail_count;

  // One scan: remote first, then keys in order, stop at the first event.
  task automatic predict_scan(input logic [NUM_KEYS-1:0] pins, input logic [TICK_W-1:0] now);
    scan_event_t ev;
    logic        cur;
    logic        found;
    ev    = '{key_index: KW'(NUM_KEYS), kind: EV_NONE, tick: '0};
    found = 1'b0;
    if (pins[NUM_KEYS-1] ^ ~cfg.remote_high) begin
      ev    = '{key_index: KW'(NUM_KEYS - 1), kind: EV_REMOTE, tick: '0};
      found = 1'b1;
    end
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (!found) begin
        cur = pins[k] ^ ~cfg.local_high;
        if (cur != key_down[k]) begin
          key_down[k] = cur;
          press_at[k] = now;
          if (cur) begin
            long_done[k] = 1'b0;
          end else if (!long_done[k]) begin
            ev    = '{key_index: KW'(k), kind: EV_SHORT, tick: now};
            found = 1'b1;
          end
        end
        if (!found && cur && !long_done[k] &&
            TICK_W'(now - press_at[k]) > TICK_W'(cfg.long_ticks)) begin
          long_done[k] = 1'b1;
          ev           = '{key_index: KW'(k), kind: EV_LONG, tick: now};
          found        = 1'b1;
        end
      end
    end
    expected_events.push_back(ev);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    scan_event_t got;
    scan_event_t want;
    if (!rst_ni) begin
      cfg.long_ticks  = LONG_TICKS_RST;
      cfg.local_high  = 1'b1;
      cfg.remote_high = 1'b1;
      key_down        = '0;
      long_done       = '0;
      for (int k = 0; k < NUM_KEYS; k++) press_at[k] = '0;
      expected_events.delete();
      fail_count      = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // check the output first: a result can never belong to a scan taken at this same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[EV_W-1:0];
        if (expected_events.size() == 0) begin
          $error("result with no scan pending: key_index %0d event_kind %0d event_tick %0d",
                 got.key_index, got.kind, got.tick);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (got.key_index !== want.key_index) begin
            $error("key_index: expected %0d, actual %0d", want.key_index, got.key_index);
            fail_count++;
          end
          if (got.kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, got.kind);
            fail_count++;
          end
          if (got.tick !== want.tick) begin
            $error("event_tick: expected %0d, actual %0d", want.tick, got.tick);
            fail_count++;
          end
        end
        if (m_axis_tdata[OUT_W-1:EV_W] !== '0) begin
          $error("tdata fill: expected 0, actual %0h", m_axis_tdata[OUT_W-1:EV_W]);
          fail_count++;
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        predict_scan(s_axis_tdata[NUM_KEYS-1:0], s_axis_tdata[NUM_KEYS +: TICK_W]);
      end

      // values are masked to the register widths, unmapped indexes dropped
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_LONG_TICKS:  cfg.long_ticks  = cfg_data_i[HOLD_W-1:0];
          REG_LOCAL_HIGH:  cfg.local_high  = cfg_data_i[0];
          REG_REMOTE_HIGH: cfg.remote_high = cfg_data_i[0];
          default: ;
        endcase
      end

      pending_o <= expected_events.size();
      errors_o  <= fail_count;
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the key press scanner: clock, reset, scan stimulus, output stalls, verdict.
module testbench;
  import kslp_pkg::*;

  localparam int unsigned NUM_KEYS = NUM_KEYS_DEF;
  localparam int unsigned KW       = $clog2(NUM_KEYS + 1);
  localparam int unsigned IN_W     = ((NUM_KEYS + TICK_W + 7) / 8) * 8;
  localparam int unsigned OUT_W    = ((KW + 2 + TICK_W + 7) / 8) * 8;

  // Unmapped register index; writes to it must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int SCANS_PER_SETTING = 78;          // 3 phases x 3 settings, about 700 scans
  localparam int DRAIN_CYCLES      = NUM_KEYS + 8; // drain wait, covering a full scan plus margin
  localparam int HOLD_OFF_CYCLES   = 300;          // long output stall in the last phase

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // tdata from bit 0: pin_levels [NUM_KEYS], now_tick [32], zero fill
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // tdata from bit 0: key_index [KW], event_kind [2], event_tick [32], zero fill
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int pending;
  int errors;

  // Idle rates in percent and the stall request; all changed with NBAs at a clock edge.
  int   send_idle_pct = 10;
  int   recv_idle_pct = 30;
  logic rx_hold       = 1'b0;
  int   phase_no      = -1;

  // Stimulus-side view: polarities in force, raw local key pins, running tick.
  logic                  local_high_now  = 1'b1;
  logic                  remote_high_now = 1'b1;
  logic [NUM_KEYS-2:0]   key_pins        = '0;
  logic [TICK_W-1:0]     tick_now        = '0;

  key_short_long_press_scanner_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  kslp_event_checker u_event_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Send one scan transaction. valid is only dropped during an idle gap, so back-to-back
  // transactions keep it high without a drop and raise in the same step.
  task automatic send_scan(input logic [NUM_KEYS-1:0] pins, input logic [TICK_W-1:0] stamp);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({stamp, pins});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Every scan yields a result, so an empty scoreboard means the block is idle.
  // The first edge lets the checker's count catch up with the last accepted transaction.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Writes all registers plus the unmapped index; the 1-bit registers get junk in the
  // upper data bits to exercise masking.
  task automatic program_config(input logic [HOLD_W-1:0] hold, input logic loc_high,
                                input logic rem_high);
    write_reg(REG_LONG_TICKS, CFG_DATA_W'(hold));
    write_reg(REG_LOCAL_HIGH, {(CFG_DATA_W-1)'($urandom), loc_high});
    write_reg(REG_REMOTE_HIGH, {(CFG_DATA_W-1)'($urandom), rem_high});
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid_i     <= 1'b0;
    local_high_now  = loc_high;
    remote_high_now = rem_high;
  endtask

  // Mostly realistic scans: keys toggle now and then, the tick creeps forward so holds
  // cross the long-press threshold, the remote pin is rarely active. A few scans are
  // pure noise, and a few jump the tick close to wrap.
  task automatic random_scans(input int count, input int step_max);
    logic [NUM_KEYS-1:0] pins;
    logic [TICK_W-1:0]   stamp;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99, 0) < 8) begin
        pins  = NUM_KEYS'($urandom);
        stamp = $urandom;
      end else begin
        for (int k = 0; k < NUM_KEYS - 1; k++) begin
          if ($urandom_range(99, 0) < 8) key_pins[k] = ~key_pins[k];
        end
        if ($urandom_range(99, 0) < 2) begin
          tick_now = {TICK_W{1'b1}} - TICK_W'($urandom_range(step_max * 4, 0));
        end else begin
          tick_now = tick_now + TICK_W'($urandom_range(step_max, 0));
        end
        pins[NUM_KEYS-2:0] = key_pins;
        pins[NUM_KEYS-1]   = ($urandom_range(99, 0) < 5) ? remote_high_now : ~remote_high_now;
        stamp              = tick_now;
      end
      send_scan(pins, stamp);
    end
  endtask

  // Output side: random stalls, or a solid stall while a hold-off is requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // Pressure: in the last phase the output stalls long enough for the scanner to fill
  // up and push back on s_axis while scans keep being offered.
  initial begin
    wait (phase_no == 2);
    repeat (40) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin : stimulus
    logic [HOLD_W-1:0] hold;
    logic              loc_high;
    logic              rem_high;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_LONG_TICKS;
    cfg_data_i    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset settings: threshold 1000, both polarities active high.
    send_scan(9'h000, 32'd0);          // no event
    send_scan(9'h001, 32'd100);        // press key 0
    send_scan(9'h001, 32'd1100);       // held exactly the threshold: not long yet
    send_scan(9'h001, 32'd1101);       // long on key 0
    send_scan(9'h000, 32'd1200);       // release after long: silent
    send_scan(9'h008, 32'd2000);       // press key 3
    send_scan(9'h000, 32'd2100);       // short on key 3
    send_scan(9'h100, 32'd2200);       // remote active
    send_scan(9'h1FF, 32'd2300);       // remote active, key changes must not stick
    send_scan(9'h0FF, 32'd3000);       // all local keys down at once
    send_scan(9'h000, 32'd3010);       // releases come out one per scan, lowest first
    send_scan(9'h000, 32'd3020);
    send_scan(9'h0FC, 32'd3030);
    send_scan(9'h0FC, 32'd4031);       // long on key 2
    send_scan(9'h0FC, 32'd4032);       // then key 3
    send_scan(9'h000, 32'hFFFF_FF00);
    send_scan(9'h000, 32'hFFFF_FF01);
    send_scan(9'h020, 32'hFFFF_FF10);  // press key 5 just before the tick wraps
    send_scan(9'h020, 32'h0000_0300);  // long on key 5 across the wrap
    send_scan(9'h0FF, 32'hFFFF_FFFF);

    // Both polarities low, widest threshold.
    wait_idle();
    program_config(16'hFFFF, 1'b0, 1'b0);
    send_scan(9'h000, 32'd5);          // remote active low
    send_scan(9'h1FF, 32'd6);          // every key reads released
    send_scan(9'h1FE, 32'd7);          // key 0 reads pressed

    // Remote low, local high, zero threshold: a high remote pin is key 8 being pressed.
    wait_idle();
    program_config(16'h0000, 1'b1, 1'b0);
    send_scan(9'h100, 32'd100);
    send_scan(9'h100, 32'd101);

    // Random phases: receiver idles more, then sender idles more, then nobody idles.
    for (int ph = 0; ph < 3; ph++) begin
      phase_no      <= ph;
      send_idle_pct <= (ph == 0) ? 25 : (ph == 1) ? 64 : 0;
      recv_idle_pct <= (ph == 0) ? 64 : (ph == 1) ? 25 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        case (seg)
          0:       hold = HOLD_W'($urandom_range(400, 16));
          1:       hold = (ph == 1) ? {HOLD_W{1'b1}} : '0;
          default: hold = HOLD_W'($urandom);
        endcase
        loc_high = 1'($urandom);
        rem_high = 1'($urandom);
        wait_idle();
        program_config(hold, loc_high, rem_high);
        random_scans(SCANS_PER_SETTING, int'(hold) / 4 + 8);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("** key_short_long_press_scanner_top: PASSED **");
    end else begin
      $display("** key_short_long_press_scanner_top: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(5_000_000);
    $display("** key_short_long_press_scanner_top: FAILED **");
    $finish;
  end

endmodule
